// File: hw/rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ARXMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion on the edge after a condition, off while reset is asserted
`define ARXMR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> prop) \
        else $error(msg);

`endif

// File: hw/rtl/arxmr_pkg.sv
package arxmr_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 4;
    localparam int LAG_REGS  = 4;
    localparam int EXOG_REGS = 2;
    localparam int TERMS     = LAG_REGS + EXOG_REGS;
    localparam int REG_IDX_W = 3;

    localparam int DEF_LAGS       = 4;
    localparam int DEF_EXOG_COUNT = 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_W-1){1'b1}}});
    localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_W-1){1'b0}}});

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INTERCEPT  = 3'd0,
        REG_LAG_ONE    = 3'd1,
        REG_LAG_TWO    = 3'd2,
        REG_LAG_THREE  = 3'd3,
        REG_LAG_FOUR   = 3'd4,
        REG_EXOG_ONE   = 3'd5,
        REG_EXOG_TWO   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        data_t                  intercept;
        data_t [LAG_REGS-1:0]   lag;
        data_t [EXOG_REGS-1:0]  exog;
    } coef_t;

    // operands of one item after the history lookup
    typedef struct packed {
        data_t                  y;
        data_t [LAG_REGS-1:0]   lag;
        data_t [EXOG_REGS-1:0]  exog;
    } opnd_t;

endpackage

// File: hw/rtl/arxmr_cfg.sv
module arxmr_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [arxmr_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [arxmr_pkg::DATA_W-1:0]        cfg_data,
    output arxmr_pkg::coef_t                    coef
);

    arxmr_pkg::coef_t coef_reg;
    arxmr_pkg::coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_write)
        begin
            case (arxmr_pkg::reg_idx_t'(cfg_index))
                arxmr_pkg::REG_INTERCEPT: coef_next.intercept = cfg_data;
                arxmr_pkg::REG_LAG_ONE:   coef_next.lag[0]    = cfg_data;
                arxmr_pkg::REG_LAG_TWO:   coef_next.lag[1]    = cfg_data;
                arxmr_pkg::REG_LAG_THREE: coef_next.lag[2]    = cfg_data;
                arxmr_pkg::REG_LAG_FOUR:  coef_next.lag[3]    = cfg_data;
                arxmr_pkg::REG_EXOG_ONE:  coef_next.exog[0]   = cfg_data;
                arxmr_pkg::REG_EXOG_TWO:  coef_next.exog[1]   = cfg_data;
                default:                  coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// File: hw/rtl/arxmr_front.sv
module arxmr_front
#(
    parameter int LAGS       = arxmr_pkg::DEF_LAGS,
    parameter int EXOG_COUNT = arxmr_pkg::DEF_EXOG_COUNT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  arxmr_pkg::data_t    sample_value,
    input  arxmr_pkg::data_t    exog_one,
    input  arxmr_pkg::data_t    exog_two,
    input  logic                series_start,
    output logic                op_valid,
    input  logic                op_ready,
    output arxmr_pkg::opnd_t    op
);

    arxmr_pkg::data_t hist_reg  [LAGS];
    arxmr_pkg::data_t hist_next [LAGS];
    arxmr_pkg::data_t [arxmr_pkg::LAG_REGS-1:0] hist_tap;
    arxmr_pkg::opnd_t op_reg;
    arxmr_pkg::opnd_t op_next;
    logic             op_valid_reg;
    logic             op_valid_next;
    logic             ready;
    logic             accept;

    // lags beyond the history depth read as zero
    for (genvar g = 0; g < arxmr_pkg::LAG_REGS; g++)
    begin : g_tap
        if (g < LAGS)
        begin : g_used
            assign hist_tap[g] = hist_reg[g];
        end
        else
        begin : g_zero
            assign hist_tap[g] = '0;
        end
    end

    assign ready  = !op_valid_reg || op_ready;
    assign accept = in_valid && ready;

    always_comb
    begin
        op_next       = op_reg;
        hist_next     = hist_reg;
        op_valid_next = op_valid_reg;
        if (ready)
        begin
            op_valid_next = in_valid;
        end
        if (accept)
        begin
            op_next.y       = sample_value;
            for (int i = 0; i < arxmr_pkg::LAG_REGS; i++)
            begin
                op_next.lag[i] = series_start ? '0 : hist_tap[i];
            end
            op_next.exog[0] = (EXOG_COUNT > 0) ? exog_one : '0;
            op_next.exog[1] = (EXOG_COUNT > 1) ? exog_two : '0;
            hist_next[0]    = sample_value;
            for (int i = 1; i < LAGS; i++)
            begin
                hist_next[i] = series_start ? '0 : hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
            for (int i = 0; i < LAGS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            op_valid_reg <= op_valid_next;
            hist_reg     <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

    assign in_stall = !ready;
    assign op_valid = op_valid_reg;
    assign op       = op_reg;

endmodule

// File: hw/rtl/arxmr_mac.sv
module arxmr_mac
(
    input  logic                clk,
    input  logic                rst_n,
    input  arxmr_pkg::coef_t    coef,
    input  logic                op_valid,
    output logic                op_ready,
    input  arxmr_pkg::opnd_t    op,
    output logic                sum_valid,
    input  logic                sum_ready,
    output arxmr_pkg::acc_t     sum,
    output arxmr_pkg::data_t    sum_y
);

    arxmr_pkg::prod_t prod_reg  [arxmr_pkg::TERMS];
    arxmr_pkg::prod_t prod_next [arxmr_pkg::TERMS];
    arxmr_pkg::data_t p_y_reg;
    logic             p_valid_reg;
    arxmr_pkg::acc_t  sum_reg;
    arxmr_pkg::acc_t  sum_next;
    arxmr_pkg::data_t s_y_reg;
    logic             s_valid_reg;
    logic             p_ready;
    logic             s_ready;

    assign s_ready = !s_valid_reg || sum_ready;
    assign p_ready = !p_valid_reg || s_ready;

    // one 32x32 product per term, each registered
    always_comb
    begin
        for (int i = 0; i < arxmr_pkg::LAG_REGS; i++)
        begin
            prod_next[i] = arxmr_pkg::prod_t'(coef.lag[i]) * arxmr_pkg::prod_t'(op.lag[i]);
        end
        for (int i = 0; i < arxmr_pkg::EXOG_REGS; i++)
        begin
            prod_next[arxmr_pkg::LAG_REGS + i] = arxmr_pkg::prod_t'(coef.exog[i])
                                               * arxmr_pkg::prod_t'(op.exog[i]);
        end
    end

    // intercept enters at the Q32.32 scale so one floor shift covers everything
    always_comb
    begin
        sum_next = arxmr_pkg::acc_t'(coef.intercept) <<< arxmr_pkg::FRAC_W;
        for (int i = 0; i < arxmr_pkg::TERMS; i++)
        begin
            sum_next = sum_next + arxmr_pkg::acc_t'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= op_valid;
            end
            if (s_ready)
            begin
                s_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid && p_ready)
        begin
            prod_reg <= prod_next;
            p_y_reg  <= op.y;
        end
        if (p_valid_reg && s_ready)
        begin
            sum_reg <= sum_next;
            s_y_reg <= p_y_reg;
        end
    end

    assign op_ready  = p_ready;
    assign sum_valid = s_valid_reg;
    assign sum       = sum_reg;
    assign sum_y     = s_y_reg;

endmodule

// File: hw/rtl/arxmr_sat.sv
module arxmr_sat
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sum_valid,
    output logic                sum_ready,
    input  arxmr_pkg::acc_t     sum,
    input  arxmr_pkg::data_t    sum_y,
    output logic                out_valid,
    input  logic                out_stall,
    output arxmr_pkg::data_t    predicted_mean,
    output arxmr_pkg::data_t    residual,
    output logic                saturated
);

    localparam int HI_W = arxmr_pkg::ACC_W - arxmr_pkg::FRAC_W - arxmr_pkg::DATA_W + 1;

    arxmr_pkg::acc_t                    mean_wide;
    logic [HI_W-1:0]                    mean_hi;
    logic                               mean_clip;
    arxmr_pkg::data_t                   mean_sat;
    logic signed [arxmr_pkg::DATA_W:0]  diff;
    logic                               res_clip;
    arxmr_pkg::data_t                   res_sat;

    logic             out_valid_reg;
    arxmr_pkg::data_t mean_reg;
    arxmr_pkg::data_t res_reg;
    logic             sat_reg;
    logic             ready;

    // floor to Q16.16, then clip when the upper bits are not a pure sign extension
    assign mean_wide = sum >>> arxmr_pkg::FRAC_W;
    assign mean_hi   = mean_wide[arxmr_pkg::ACC_W-arxmr_pkg::FRAC_W-1:arxmr_pkg::DATA_W-1];
    assign mean_clip = !(&mean_hi) && (|mean_hi);
    assign mean_sat  = mean_clip ?
                       (mean_wide[arxmr_pkg::ACC_W-1] ? arxmr_pkg::DATA_MIN : arxmr_pkg::DATA_MAX)
                       : mean_wide[arxmr_pkg::DATA_W-1:0];

    assign diff     = {sum_y[arxmr_pkg::DATA_W-1], sum_y}
                    - {mean_sat[arxmr_pkg::DATA_W-1], mean_sat};
    assign res_clip = diff[arxmr_pkg::DATA_W] != diff[arxmr_pkg::DATA_W-1];
    assign res_sat  = res_clip ?
                      (diff[arxmr_pkg::DATA_W] ? arxmr_pkg::DATA_MIN : arxmr_pkg::DATA_MAX)
                      : diff[arxmr_pkg::DATA_W-1:0];

    assign ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid && ready)
        begin
            mean_reg <= mean_sat;
            res_reg  <= res_sat;
            sat_reg  <= mean_clip || res_clip;
        end
    end

    assign sum_ready      = ready;
    assign out_valid      = out_valid_reg;
    assign predicted_mean = mean_reg;
    assign residual       = res_reg;
    assign saturated      = sat_reg;

endmodule

// File: hw/rtl/arx_mean_residual_filter_top.sv
// channel   direction  handshake              payload
// in        into       in_valid / in_stall    sample_value, exog_one, exog_two, series_start
// out       out of     out_valid / out_stall  predicted_mean, residual, saturated
// cfg       into       cfg_write              cfg_index, cfg_data
//
// one item per clock sustained while out_stall stays low; an item goes from accept to out_valid
// (accept loads the input register, then product, sum and result registers)
// the six 32x32 products and the seven-term sum each take one pipeline stage
// reset clears the coefficients, the sample history and all stage valids
// stages advance independently, so bubbles fill while out_stall holds a result
module arx_mean_residual_filter_top
#(
    parameter int LAGS       = arxmr_pkg::DEF_LAGS,
    parameter int EXOG_COUNT = arxmr_pkg::DEF_EXOG_COUNT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [arxmr_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [arxmr_pkg::DATA_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [arxmr_pkg::DATA_W-1:0] sample_value,
    input  logic signed [arxmr_pkg::DATA_W-1:0] exog_one,
    input  logic signed [arxmr_pkg::DATA_W-1:0] exog_two,
    input  logic                                series_start,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [arxmr_pkg::DATA_W-1:0] predicted_mean,
    output logic signed [arxmr_pkg::DATA_W-1:0] residual,
    output logic                                saturated
);

    arxmr_pkg::coef_t coef;
    arxmr_pkg::opnd_t op;
    logic             op_valid;
    logic             op_ready;
    arxmr_pkg::acc_t  sum;
    arxmr_pkg::data_t sum_y;
    logic             sum_valid;
    logic             sum_ready;

    arxmr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    arxmr_front
    #(
        .LAGS       (LAGS),
        .EXOG_COUNT (EXOG_COUNT)
    )
    u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .exog_one     (exog_one),
        .exog_two     (exog_two),
        .series_start (series_start),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (op)
    );

    arxmr_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum),
        .sum_y     (sum_y)
    );

    arxmr_sat u_sat
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sum_valid      (sum_valid),
        .sum_ready      (sum_ready),
        .sum            (sum),
        .sum_y          (sum_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .predicted_mean (predicted_mean),
        .residual       (residual),
        .saturated      (saturated)
    );

endmodule

// File: hw/rtl/arxmr_checker.sv
`include "assert_macros.svh"

module arxmr_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [arxmr_pkg::DATA_W-1:0] predicted_mean,
    input logic signed [arxmr_pkg::DATA_W-1:0] residual,
    input logic                                saturated
);

    `ARXMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out item dropped while stalled")

    `ARXMR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(predicted_mean) && $stable(residual) && $stable(saturated), "out item changed while stalled")

    // input may only back up once the whole pipeline is full behind a stalled result
    `ARXMR_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with room in the pipeline")

    // a clipped item must show a rail value on the mean or the residual
    `ARXMR_ASSERT(a_sat_rail, out_valid && saturated |-> predicted_mean == arxmr_pkg::DATA_MAX || predicted_mean == arxmr_pkg::DATA_MIN || residual == arxmr_pkg::DATA_MAX || residual == arxmr_pkg::DATA_MIN, "saturated without a rail value")

endmodule

bind arx_mean_residual_filter_top arxmr_checker u_arxmr_checker (.*);

// File: sim/arx_mean_residual_filter_top_test.sv
module arx_mean_residual_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef arxmr_pkg::data_t data_t;

    localparam data_t DATA_MAX = arxmr_pkg::DATA_MAX;
    localparam data_t DATA_MIN = arxmr_pkg::DATA_MIN;
    localparam int LAG_REGS = arxmr_pkg::LAG_REGS;
    localparam int EXOG_REGS = arxmr_pkg::EXOG_REGS;
    localparam int FRAC_W = arxmr_pkg::FRAC_W;
    localparam logic [arxmr_pkg::REG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 125;

    typedef struct {
        data_t sample;
        data_t x1;
        data_t x2;
        logic  start;
    } sample_item_t;

    typedef struct {
        data_t mean;
        data_t resid;
        logic  sat;
    } arx_result_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  cfg_write = 1'b0;
    logic [arxmr_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [arxmr_pkg::DATA_W-1:0] cfg_data = '0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    data_t sample_value = '0;
    data_t exog_one = '0;
    data_t exog_two = '0;
    logic  series_start = 1'b0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    data_t predicted_mean;
    data_t residual;
    logic  saturated;

    sample_item_t item_queue[$];
    arx_result_t  mean_expected[$];

    // predictor copy of the coefficients and the sample history
    data_t coef_intercept;
    data_t lag_coef[LAG_REGS];
    data_t exog_coef[EXOG_REGS];
    data_t history[LAG_REGS];

    int error_count = 0;
    int cyc = 0;
    int idle_cycles = 0;
    logic quiet;

    arx_mean_residual_filter_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_value   (sample_value),
        .exog_one       (exog_one),
        .exog_two       (exog_two),
        .series_start   (series_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .predicted_mean (predicted_mean),
        .residual       (residual),
        .saturated      (saturated)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // stretch with no idling on either side
    assign quiet = (cyc >= 500) && (cyc < 850);

    function automatic arx_result_t predict_arx(sample_item_t it);
        logic signed [71:0] acc;
        longint prod;
        logic signed [33:0] ys;
        logic signed [33:0] ms;
        logic signed [33:0] diff;
        arx_result_t r;
        begin
            r.sat = 1'b0;
            if (it.start)
            begin
                for (int i = 0; i < LAG_REGS; i++)
                    history[i] = '0;
            end
            acc = coef_intercept;
            acc = acc <<< FRAC_W;
            for (int i = 0; i < LAG_REGS; i++)
            begin
                prod = longint'(lag_coef[i]) * longint'(history[i]);
                acc = acc + prod;
            end
            prod = longint'(exog_coef[0]) * longint'(it.x1);
            acc = acc + prod;
            prod = longint'(exog_coef[1]) * longint'(it.x2);
            acc = acc + prod;
            acc = acc >>> FRAC_W;
            if (acc > DATA_MAX)
            begin
                r.mean = DATA_MAX;
                r.sat = 1'b1;
            end
            else if (acc < DATA_MIN)
            begin
                r.mean = DATA_MIN;
                r.sat = 1'b1;
            end
            else
                r.mean = data_t'(acc);
            ys = it.sample;
            ms = r.mean;
            diff = ys - ms;
            if (diff > DATA_MAX)
            begin
                r.resid = DATA_MAX;
                r.sat = 1'b1;
            end
            else if (diff < DATA_MIN)
            begin
                r.resid = DATA_MIN;
                r.sat = 1'b1;
            end
            else
                r.resid = data_t'(diff);
            for (int i = LAG_REGS - 1; i > 0; i--)
                history[i] = history[i-1];
            history[0] = it.sample;
            return r;
        end
    endfunction

    function automatic data_t rand_value();
        case ($urandom_range(0, 9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return '0;
            3, 4, 5, 6: return data_t'($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
            default: return data_t'($urandom);
        endcase
    endfunction

    function automatic data_t rand_coef();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DATA_MAX;
            2: return DATA_MIN;
            3, 4: return data_t'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return data_t'($urandom);
        endcase
    endfunction

    task automatic queue_item(input data_t y, input data_t x1, input data_t x2, input logic st);
        sample_item_t it;
        begin
            it.sample = y;
            it.x1 = x1;
            it.x2 = x2;
            it.start = st;
            item_queue.push_back(it);
        end
    endtask

    task automatic write_reg(input logic [arxmr_pkg::REG_IDX_W-1:0] idx, input data_t val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_coefs(input data_t ic, input data_t l1, input data_t l2, input data_t l3,
                             input data_t l4, input data_t e1, input data_t e2);
        write_reg(arxmr_pkg::REG_INTERCEPT, ic);
        write_reg(arxmr_pkg::REG_LAG_ONE, l1);
        write_reg(arxmr_pkg::REG_LAG_TWO, l2);
        write_reg(arxmr_pkg::REG_LAG_THREE, l3);
        write_reg(arxmr_pkg::REG_LAG_FOUR, l4);
        write_reg(arxmr_pkg::REG_EXOG_ONE, e1);
        write_reg(arxmr_pkg::REG_EXOG_TWO, e2);
    endtask

    task automatic wait_drained();
        while (item_queue.size() != 0 || in_valid || mean_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // well-formed series of random length, with a stray series start now and then
    task automatic queue_random_series(input int count);
        int left;
        logic st;
        begin
            left = 0;
            for (int n = 0; n < count; n++)
            begin
                st = (left == 0) || ($urandom_range(0, 19) == 0);
                if (left == 0)
                    left = $urandom_range(1, 12);
                left--;
                queue_item(rand_value(), rand_value(), rand_value(), st);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // coefficients straight out of reset
        queue_item(DATA_MAX, DATA_MAX, DATA_MIN, 1'b1);
        queue_item(DATA_MIN, 32'sh10000, 32'sh10000, 1'b0);
        wait_drained();

        set_coefs(32'sh10000, 32'sh8000, 32'sh4000, -32'sh4000, 32'sh2000,
                  32'sh10000, -32'sh20000);
        queue_item(32'sh10000, 32'sh8000, 32'sh4000, 1'b1);
        queue_item(32'sh20000, '0, '0, 1'b0);
        queue_item(32'sh30000, 32'sh1, -32'sh1, 1'b0);
        queue_item(32'sh40000, '0, '0, 1'b0);
        queue_item(32'sh50000, '0, '0, 1'b0);
        queue_item(32'sh60000, '0, '0, 1'b0);
        queue_item(-32'sh1, DATA_MAX, DATA_MIN, 1'b1);
        queue_item(DATA_MAX, DATA_MIN, '0, 1'b0);
        queue_item(DATA_MIN, DATA_MAX, '0, 1'b0);
        wait_drained();

        // unknown index leaves the coefficients alone
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        queue_item(32'sh10000, 32'sh10000, 32'sh10000, 1'b0);
        wait_drained();

        set_coefs(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
        queue_item(DATA_MAX, DATA_MAX, DATA_MAX, 1'b1);
        queue_item(DATA_MIN, DATA_MIN, DATA_MIN, 1'b0);
        queue_item(DATA_MIN, '0, '0, 1'b1);
        queue_item('0, 32'sh1, 32'sh1, 1'b0);
        wait_drained();

        set_coefs(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
        queue_item(DATA_MIN, DATA_MIN, DATA_MIN, 1'b1);
        queue_item(DATA_MIN, DATA_MAX, DATA_MIN, 1'b0);
        queue_item(DATA_MAX, '0, '0, 1'b1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                set_coefs(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
            else if (p == 1)
                set_coefs(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
            else
                set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                          rand_coef(), rand_coef(), rand_coef());
            write_reg(REG_NONE, data_t'($urandom));
            queue_random_series(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // predictor copy of the coefficient registers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_intercept <= '0;
            for (int i = 0; i < LAG_REGS; i++)
                lag_coef[i] <= '0;
            for (int i = 0; i < EXOG_REGS; i++)
                exog_coef[i] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                arxmr_pkg::REG_INTERCEPT: coef_intercept <= cfg_data;
                arxmr_pkg::REG_LAG_ONE:   lag_coef[0] <= cfg_data;
                arxmr_pkg::REG_LAG_TWO:   lag_coef[1] <= cfg_data;
                arxmr_pkg::REG_LAG_THREE: lag_coef[2] <= cfg_data;
                arxmr_pkg::REG_LAG_FOUR:  lag_coef[3] <= cfg_data;
                arxmr_pkg::REG_EXOG_ONE:  exog_coef[0] <= cfg_data;
                arxmr_pkg::REG_EXOG_TWO:  exog_coef[1] <= cfg_data;
                default: ;
            endcase
        end
    end

    initial
    begin
        for (int i = 0; i < LAG_REGS; i++)
            history[i] = '0;
    end

    // input driver; the expected result is formed when the item is accepted
    always @(posedge clk or negedge rst_n)
    begin
        sample_item_t it;
        sample_item_t taken;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken.sample = sample_value;
                taken.x1 = exog_one;
                taken.x2 = exog_two;
                taken.start = series_start;
                mean_expected.push_back(predict_arx(taken));
            end
            if (!in_valid || !in_stall)
            begin
                if (item_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 26))
                begin
                    it = item_queue.pop_front();
                    sample_value <= it.sample;
                    exog_one <= it.x1;
                    exog_two <= it.x2;
                    series_start <= it.start;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 26);
    end

    // result monitor
    always @(posedge clk)
    begin
        arx_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (mean_expected.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing expected: mean %h residual %h sat %b",
                         $time, predicted_mean, residual, saturated);
            end
            else
            begin
                want = mean_expected.pop_front();
                if (predicted_mean !== want.mean)
                begin
                    error_count++;
                    $display("%0t: predicted_mean expected %h actual %h",
                             $time, want.mean, predicted_mean);
                end
                if (residual !== want.resid)
                begin
                    error_count++;
                    $display("%0t: residual expected %h actual %h",
                             $time, want.resid, residual);
                end
                if (saturated !== want.sat)
                begin
                    error_count++;
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.sat, saturated);
                end
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
